// ===== hw/rtl/assert_macros.svh =====
// Assertion helpers shared by the RTL.
// ASSERT_PROP checks a property on every rising edge out of reset.
// ASSERT_NEVER flags a condition that must not occur.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define ASSERT_PROP(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("assertion failed");
`define ASSERT_NEVER(label, clk, rst, expr) \
   label: assert property (@(posedge clk) disable iff (rst) !(expr)) \
      else $error("forbidden condition seen");
`else
`define ASSERT_PROP(label, clk, rst, prop)
`define ASSERT_NEVER(label, clk, rst, expr)
`endif
`endif

// ===== hw/rtl/tgc_pkg.sv =====
`default_nettype none
package tgc_pkg;

   // field and datapath widths
   localparam int FieldW  = 12;
   localparam int ProdW   = 2 * FieldW;
   localparam int SpeedW  = 22;
   localparam int CountW  = 5;
   localparam int CsrIdxW = 3;

   // block constants
   localparam int                CoordBits  = 12;
   localparam logic [FieldW-1:0] CoordMax   = FieldW'((1 << CoordBits) - 1);
   localparam logic [FieldW-1:0] WindowTop  = 12'd0;
   localparam logic [FieldW-1:0] SmallMove  = 12'd3;
   localparam logic [FieldW-1:0] SpeedScale = 12'd1000;
   localparam logic [SpeedW-1:0] SpeedMax   = 22'd4095000;

   // serial unit step counts
   localparam int MulSteps = FieldW;
   localparam int DivSteps = ProdW;

   // poll status codes
   localparam logic [1:0] STAT_TOUCH = 2'd0;
   localparam logic [1:0] STAT_NONE  = 2'd1;
   localparam logic [1:0] STAT_ERROR = 2'd2;

   // configuration register indexes
   localparam logic [CsrIdxW-1:0] CSR_MOVE_THRESHOLD = 3'd0;
   localparam logic [CsrIdxW-1:0] CSR_SCREEN_WIDTH   = 3'd1;
   localparam logic [CsrIdxW-1:0] CSR_SCREEN_HEIGHT  = 3'd2;
   localparam logic [CsrIdxW-1:0] CSR_PANEL_WIDTH    = 3'd3;
   localparam logic [CsrIdxW-1:0] CSR_PANEL_HEIGHT   = 3'd4;
   localparam logic [CsrIdxW-1:0] CSR_WINDOW_LEFT    = 3'd5;
   localparam logic [CsrIdxW-1:0] CSR_WINDOW_RIGHT   = 3'd6;
   localparam logic [CsrIdxW-1:0] CSR_WINDOW_BOTTOM  = 3'd7;

   typedef enum logic [1:0] {
      GEST_NONE  = 2'd0,
      GEST_PRESS = 2'd1,
      GEST_MOVE  = 2'd2,
      GEST_ERROR = 2'd3
   } gesture_type;

   typedef enum logic [1:0] {
      DIR_RIGHT = 2'd0,
      DIR_LEFT  = 2'd1,
      DIR_DOWN  = 2'd2,
      DIR_UP    = 2'd3
   } dir_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_SCALE_X,
      S_SCALE_Y,
      S_DECIDE,
      S_SPEED,
      S_UPDATE
   } top_state_type;

   typedef enum logic [1:0] {
      MD_IDLE,
      MD_MUL,
      MD_DIV
   } md_state_type;

   // multiply-divide unit: quot = mul_a * mul_b / den
   typedef struct packed {
      logic              start;
      logic [FieldW-1:0] mul_a;
      logic [FieldW-1:0] mul_b;
      logic [FieldW-1:0] den;
   } md_req_type;

   typedef struct packed {
      logic             done;
      logic [ProdW-1:0] quot;
   } md_rsp_type;

endpackage
`default_nettype wire

// ===== hw/rtl/tgc_req_if.sv =====
`default_nettype none
interface tgc_req_if import tgc_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [1:0]        poll_status;
   logic [FieldW-1:0] raw_x;
   logic [FieldW-1:0] raw_y;

   modport source (output valid, output poll_status, output raw_x, output raw_y,
                   input ready);
   modport sink (input valid, input poll_status, input raw_x, input raw_y,
                 output ready);
endinterface
`default_nettype wire

// ===== hw/rtl/tgc_rsp_if.sv =====
`default_nettype none
interface tgc_rsp_if import tgc_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [1:0]        gesture;
   logic [FieldW-1:0] pos_x;
   logic [FieldW-1:0] pos_y;
   logic [1:0]        direction;
   logic [SpeedW-1:0] speed;

   modport source (output valid, output gesture, output pos_x, output pos_y,
                   output direction, output speed, input ready);
   modport sink (input valid, input gesture, input pos_x, input pos_y,
                 input direction, input speed, output ready);
endinterface
`default_nettype wire

// ===== hw/rtl/tgc_muldiv.sv =====
`default_nettype none
`include "assert_macros.svh"
// Bit-serial a*b/den: shift-add multiply, then restoring divide.
module tgc_muldiv import tgc_pkg::*; (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire md_req_type md_req,
   output md_rsp_type      md_rsp
);

   md_state_type      state_ff, state_in;
   logic [CountW-1:0] count_ff, count_in;
   logic [ProdW-1:0]  mcand_ff, mcand_in;
   logic [FieldW-1:0] mplier_ff, mplier_in;
   logic [ProdW-1:0]  work_ff, work_in;   // product, then dividend / quotient
   logic [FieldW:0]   rem_ff, rem_in;
   logic [FieldW-1:0] den_ff, den_in;
   logic              done_ff, done_in;

   logic [FieldW:0]   rem_sh;
   logic [FieldW+1:0] diff;

   assign rem_sh = {rem_ff[FieldW-1:0], work_ff[ProdW-1]};
   assign diff   = {1'b0, rem_sh} - {2'b00, den_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= MD_IDLE;
         count_ff <= '0;
         done_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         done_ff  <= done_in;
      end
      mcand_ff  <= mcand_in;
      mplier_ff <= mplier_in;
      work_ff   <= work_in;
      rem_ff    <= rem_in;
      den_ff    <= den_in;
   end

   always_comb begin
      state_in  = state_ff;
      count_in  = count_ff;
      mcand_in  = mcand_ff;
      mplier_in = mplier_ff;
      work_in   = work_ff;
      rem_in    = rem_ff;
      den_in    = den_ff;
      done_in   = 1'b0;
      unique case (state_ff)
         MD_IDLE: begin
            if (md_req.start) begin
               mcand_in  = {{(ProdW-FieldW){1'b0}}, md_req.mul_a};
               mplier_in = md_req.mul_b;
               den_in    = md_req.den;
               work_in   = '0;
               count_in  = '0;
               state_in  = MD_MUL;
            end
         end
         MD_MUL: begin
            if (mplier_ff[0]) begin
               work_in = work_ff + mcand_ff;
            end
            mcand_in  = {mcand_ff[ProdW-2:0], 1'b0};
            mplier_in = {1'b0, mplier_ff[FieldW-1:1]};
            count_in  = count_ff + 1'b1;
            if (count_ff == CountW'(MulSteps - 1)) begin
               count_in = '0;
               rem_in   = '0;
               state_in = MD_DIV;
            end
         end
         MD_DIV: begin
            if (!diff[FieldW+1]) begin
               rem_in  = diff[FieldW:0];
               work_in = {work_ff[ProdW-2:0], 1'b1};
            end else begin
               rem_in  = rem_sh;
               work_in = {work_ff[ProdW-2:0], 1'b0};
            end
            count_in = count_ff + 1'b1;
            if (count_ff == CountW'(DivSteps - 1)) begin
               count_in = '0;
               done_in  = 1'b1;
               state_in = MD_IDLE;
            end
         end
         default: begin
            state_in = MD_IDLE;
         end
      endcase
   end

   assign md_rsp.done = done_ff;
   assign md_rsp.quot = work_ff;

   `ASSERT_PROP(a_start_when_idle, clock, reset, md_req.start |-> state_ff == MD_IDLE)
   `ASSERT_PROP(a_done_after_div, clock, reset, done_ff |-> $past(state_ff) == MD_DIV)
   `ASSERT_PROP(a_rem_below_den, clock, reset,
      (state_ff == MD_DIV && den_ff != '0) |-> rem_ff < (FieldW+1)'(den_ff))

endmodule
`default_nettype wire

// ===== hw/rtl/touch_gesture_classifier.sv =====
// Touch gesture classifier.
// req_if carries one touch poll per beat (poll_status, raw_x, raw_y); rsp_if
// returns exactly one result beat per request (gesture, pos_x, pos_y,
// direction, speed). Registers are written through csr_we / csr_index /
// csr_wdata, one per cycle, and must only change while the block is idle.
// One poll is handled at a time. A single bit-serial multiply-divide unit
// does the scaling and the speed: 12 multiply steps, 24 divide steps and a
// registered done per use. A poll with no touch or an error goes straight
// to the commit step; a touch scales x, then y, then decides and, for a
// move with a speed, computes the speed before the commit step.
// A new request is taken as soon as the previous result sits in the output
// register, even if the receiver has not yet taken it; the block then waits
// at the commit step while that result is stalled.
// Synchronous reset returns the registers to their defaults, sets the
// restart flag, clears the tracked point and gesture state and drops
// rsp valid; req ready stays low while reset is high.
`default_nettype none
`include "assert_macros.svh"
module touch_gesture_classifier import tgc_pkg::*; (
   input  wire logic               clock,
   input  wire logic               reset,
   tgc_req_if.sink                 req_if,
   tgc_rsp_if.source               rsp_if,
   input  wire logic               csr_we,
   input  wire logic [CsrIdxW-1:0] csr_index,
   input  wire logic [FieldW-1:0]  csr_wdata
);

   // configuration registers
   logic [FieldW-1:0] thr_ff, sw_ff, sh_ff, pw_ff, ph_ff, wl_ff, wr_ff, wb_ff;

   // sequencer
   top_state_type state_ff, state_in;
   md_req_type    md_req;
   md_rsp_type    md_rsp;
   logic          load_x, load_y, load_spd, commit, take;

   // current item
   logic [1:0]        status_ff;
   logic [FieldW-1:0] ry_ff;
   logic [FieldW-1:0] cx_ff, cy_ff;
   logic [SpeedW-1:0] spd_ff;

   // tracked state
   logic              restart_ff, restart_in;
   logic [FieldW-1:0] last_x_ff, last_y_ff;
   gesture_type       gesture_ff, gesture_in;
   dir_type           dir_ff, dir_in;
   logic [FieldW-1:0] pos_x_ff, pos_x_in, pos_y_ff, pos_y_in;
   logic [SpeedW-1:0] speed_ff, speed_in;

   // output register
   logic              rsp_valid_ff;
   gesture_type       rsp_gesture_ff;
   dir_type           rsp_dir_ff;
   logic [FieldW-1:0] rsp_pos_x_ff, rsp_pos_y_ff;
   logic [SpeedW-1:0] rsp_speed_ff;

   // classification terms; all but slot_free use only registered values
   logic              is_touch, is_error, in_win, touch;
   logic [FieldW-1:0] dx, dy, spd_dist, spd_size, coord_den, coord_sat;
   logic              move_test, small_move, x_axis, need_speed, slot_free;
   logic [SpeedW-1:0] speed_sat;

   tgc_muldiv u_muldiv (
      .clock  (clock),
      .reset  (reset),
      .md_req (md_req),
      .md_rsp (md_rsp)
   );

   // --- configuration port ---
   always_ff @(posedge clock) begin
      if (reset) begin
         thr_ff <= 12'd10;
         sw_ff  <= 12'd640;
         sh_ff  <= 12'd360;
         pw_ff  <= 12'd640;
         ph_ff  <= 12'd360;
         wl_ff  <= 12'd0;
         wr_ff  <= 12'd639;
         wb_ff  <= 12'd360;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_MOVE_THRESHOLD: thr_ff <= csr_wdata;
            CSR_SCREEN_WIDTH:   sw_ff  <= csr_wdata;
            CSR_SCREEN_HEIGHT:  sh_ff  <= csr_wdata;
            CSR_PANEL_WIDTH:    pw_ff  <= csr_wdata;
            CSR_PANEL_HEIGHT:   ph_ff  <= csr_wdata;
            CSR_WINDOW_LEFT:    wl_ff  <= csr_wdata;
            CSR_WINDOW_RIGHT:   wr_ff  <= csr_wdata;
            CSR_WINDOW_BOTTOM:  wb_ff  <= csr_wdata;
            default: begin
            end
         endcase
      end
   end

   // --- classification ---
   // status 3 is unused and counts as a read error
   assign is_touch = (status_ff == STAT_TOUCH);
   assign is_error = (status_ff != STAT_TOUCH) && (status_ff != STAT_NONE);
   assign in_win   = (cx_ff >= wl_ff) && (cx_ff <= wr_ff) &&
                     (cy_ff >= WindowTop) && (cy_ff <= wb_ff);
   // a point outside the window is handled as no touch
   assign touch    = is_touch && in_win;

   assign dx = (cx_ff > last_x_ff) ? cx_ff - last_x_ff : last_x_ff - cx_ff;
   assign dy = (cy_ff > last_y_ff) ? cy_ff - last_y_ff : last_y_ff - cy_ff;

   assign move_test  = (gesture_ff == GEST_MOVE) || (dx >= thr_ff) || (dy >= thr_ff);
   assign small_move = (dx <= SmallMove) && (dy <= SmallMove);
   assign x_axis     = (dx > dy);
   assign need_speed = touch && !restart_ff && move_test && !small_move;
   assign spd_dist   = x_axis ? dx : dy;
   assign spd_size   = x_axis ? sw_ff : sh_ff;

   // saturation of the serial unit's quotient; a zero divisor saturates too
   assign coord_den = (state_ff == S_SCALE_X) ? pw_ff : ph_ff;
   assign coord_sat = (coord_den == '0) ? CoordMax :
                      (md_rsp.quot[ProdW-1:CoordBits] != '0) ? CoordMax :
                      md_rsp.quot[FieldW-1:0];
   assign speed_sat = (spd_size == '0) ? SpeedMax :
                      (md_rsp.quot > {{(ProdW-SpeedW){1'b0}}, SpeedMax}) ? SpeedMax :
                      md_rsp.quot[SpeedW-1:0];

   assign slot_free = !rsp_valid_ff || rsp_if.ready;
   assign take      = req_if.valid && (state_ff == S_IDLE);

   // --- sequencer ---
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in     = state_ff;
      md_req.start = 1'b0;
      md_req.mul_a = '0;
      md_req.mul_b = '0;
      md_req.den   = '0;
      load_x       = 1'b0;
      load_y       = 1'b0;
      load_spd     = 1'b0;
      commit       = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            if (req_if.valid) begin
               if (req_if.poll_status == STAT_TOUCH) begin
                  md_req.start = 1'b1;
                  md_req.mul_a = req_if.raw_x;
                  md_req.mul_b = sw_ff;
                  md_req.den   = pw_ff;
                  state_in     = S_SCALE_X;
               end else begin
                  state_in = S_UPDATE;
               end
            end
         end
         S_SCALE_X: begin
            if (md_rsp.done) begin
               load_x       = 1'b1;
               md_req.start = 1'b1;
               md_req.mul_a = ry_ff;
               md_req.mul_b = sh_ff;
               md_req.den   = ph_ff;
               state_in     = S_SCALE_Y;
            end
         end
         S_SCALE_Y: begin
            if (md_rsp.done) begin
               load_y   = 1'b1;
               state_in = S_DECIDE;
            end
         end
         S_DECIDE: begin
            if (need_speed) begin
               md_req.start = 1'b1;
               md_req.mul_a = spd_dist;
               md_req.mul_b = SpeedScale;
               md_req.den   = spd_size;
               state_in     = S_SPEED;
            end else begin
               state_in = S_UPDATE;
            end
         end
         S_SPEED: begin
            if (md_rsp.done) begin
               load_spd = 1'b1;
               state_in = S_UPDATE;
            end
         end
         S_UPDATE: begin
            // hold here while a stalled result still fills the output slot
            if (slot_free) begin
               commit   = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // --- next tracked state ---
   always_comb begin
      restart_in = restart_ff;
      gesture_in = gesture_ff;
      dir_in     = dir_ff;
      pos_x_in   = pos_x_ff;
      pos_y_in   = pos_y_ff;
      speed_in   = speed_ff;
      if (touch) begin
         pos_x_in = cx_ff - wl_ff;
         pos_y_in = cy_ff - WindowTop;
         if (restart_ff) begin
            restart_in = 1'b0;
            gesture_in = GEST_NONE;
         end else if (move_test) begin
            if (small_move) begin
               // jitter: keep gesture and direction, report no speed
               speed_in = '0;
            end else begin
               gesture_in = GEST_MOVE;
               speed_in   = spd_ff;
               if (x_axis) begin
                  dir_in = (cx_ff > last_x_ff) ? DIR_RIGHT : DIR_LEFT;
               end else begin
                  dir_in = (cy_ff > last_y_ff) ? DIR_DOWN : DIR_UP;
               end
            end
         end else begin
            gesture_in = GEST_PRESS;
         end
      end else if (is_error) begin
         restart_in = 1'b1;
         gesture_in = GEST_ERROR;
      end else begin
         // release: reports a press if the touch had no gesture yet
         gesture_in = (!restart_ff && gesture_ff == GEST_NONE) ? GEST_PRESS : GEST_NONE;
         restart_in = 1'b1;
      end
   end

   // --- item, state and output registers ---
   always_ff @(posedge clock) begin
      if (take) begin
         status_ff <= req_if.poll_status;
         ry_ff     <= req_if.raw_y;
         cx_ff     <= '0;
         cy_ff     <= '0;
      end
      if (load_x) begin
         cx_ff <= coord_sat;
      end
      if (load_y) begin
         cy_ff <= coord_sat;
      end
      if (load_spd) begin
         spd_ff <= speed_sat;
      end
      if (commit) begin
         rsp_gesture_ff <= gesture_in;
         rsp_dir_ff     <= dir_in;
         rsp_pos_x_ff   <= pos_x_in;
         rsp_pos_y_ff   <= pos_y_in;
         rsp_speed_ff   <= speed_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         restart_ff   <= 1'b1;
         last_x_ff    <= '0;
         last_y_ff    <= '0;
         gesture_ff   <= GEST_NONE;
         dir_ff       <= DIR_RIGHT;
         pos_x_ff     <= '0;
         pos_y_ff     <= '0;
         speed_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (commit) begin
            restart_ff   <= restart_in;
            gesture_ff   <= gesture_in;
            dir_ff       <= dir_in;
            pos_x_ff     <= pos_x_in;
            pos_y_ff     <= pos_y_in;
            speed_ff     <= speed_in;
            // the last point is the scaled point, or zero without a touch
            last_x_ff    <= cx_ff;
            last_y_ff    <= cy_ff;
            rsp_valid_ff <= 1'b1;
         end else if (rsp_if.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   assign req_if.ready     = (state_ff == S_IDLE) && !reset;
   assign rsp_if.valid     = rsp_valid_ff;
   assign rsp_if.gesture   = rsp_gesture_ff;
   assign rsp_if.pos_x     = rsp_pos_x_ff;
   assign rsp_if.pos_y     = rsp_pos_y_ff;
   assign rsp_if.direction = rsp_dir_ff;
   assign rsp_if.speed     = rsp_speed_ff;

   `ASSERT_NEVER(a_done_while_idle, clock, reset, state_ff == S_IDLE && md_rsp.done)
   `ASSERT_PROP(a_no_error_mid_touch, clock, reset, !restart_ff |-> gesture_ff != GEST_ERROR)
   `ASSERT_PROP(a_stall_holds_commit, clock, reset,
      (state_ff == S_UPDATE && rsp_valid_ff && !rsp_if.ready) |=> state_ff == S_UPDATE)

endmodule
`default_nettype wire
